@@ src/kruskal_union_find_edge_select_core_assert.svh @@
// Assertion macros for the Kruskal edge selection core.
// Used by the checker module; has no other dependencies.
`ifndef KRUSKAL_UNION_FIND_EDGE_SELECT_CORE_ASSERT_SVH
`define KRUSKAL_UNION_FIND_EDGE_SELECT_CORE_ASSERT_SVH

// Generic clocked assertion with an active-low reset that disables it.
`define KUFES_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Shorthand on the core clock and reset.
`define KUFES_ASSERT(lbl, prop, msg) \
    `KUFES_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)

`endif

@@ src/kufes_pkg.sv @@
// Shared types and constants for the Kruskal edge selection core.
// No dependencies.
package kufes_pkg;

    localparam int NODES    = 1024;
    localparam int IDX_W    = $clog2(NODES);
    localparam int NODE_W   = 10;
    localparam int WEIGHT_W = 32;
    localparam int TOTAL_W  = 48;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic rd_en;
        idx_t rd_addr;
        logic wr_en;
        idx_t wr_addr;
        idx_t wr_data;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_COMP_RD,
        ST_COMP_WR,
        ST_LINK,
        ST_DONE
    } state_t;

endpackage

@@ src/kruskal_union_find_edge_select_core.sv @@
// Kruskal edge selection over a union-find parent table with path compression.
// The time each edge takes from acceptance until the core is ready again grows with ha+hb,
// where ha and hb are the numbers of parent hops from node_a and node_b to their
// roots; the single read port of the parent table sets this, each hop on the walk
// taking ST_FIND_RD and ST_FIND_CHK and each node compressed ST_COMP_RD and ST_COMP_WR.
// After reset the table sweeps all 1024 entries, and s_ready stays low meanwhile.
// Depends on kufes_pkg and kufes_parent_table.
module kruskal_union_find_edge_select_core
    import kufes_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [NODE_W-1:0]   s_node_a,
    input  logic [NODE_W-1:0]   s_node_b,
    input  logic [WEIGHT_W-1:0] s_edge_weight,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_accepted,
    output logic [TOTAL_W-1:0]  m_tree_weight
);

    localparam logic [NODE_W:0] NODES_LIM = (NODE_W + 1)'(NODES);

    state_t state_reg, state_next;
    idx_t   a_reg, a_next;
    idx_t   b_reg, b_next;
    idx_t   cur_reg, cur_next;
    idx_t   root_reg, root_next;
    idx_t   root_a_reg, root_a_next;
    logic   side_reg, side_next;
    logic   acc_reg, acc_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_acc_reg, m_acc_next;
    logic [TOTAL_W-1:0]  m_weight_reg, m_weight_next;

    mem_req_t         req;
    idx_t             rd_data;
    logic             tbl_busy;
    logic             in_range;
    logic [TOTAL_W:0] sum;

    kufes_parent_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rd_data (rd_data),
        .busy    (tbl_busy)
    );

    assign s_ready  = (state_reg == ST_IDLE) && !tbl_busy;
    assign in_range = ({1'b0, s_node_a} < NODES_LIM) && ({1'b0, s_node_b} < NODES_LIM);
    assign sum      = {1'b0, total_reg} + {{(TOTAL_W + 1 - WEIGHT_W){1'b0}}, w_reg};

    always_comb begin
        state_next    = state_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        cur_next      = cur_reg;
        root_next     = root_reg;
        root_a_next   = root_a_reg;
        side_next     = side_reg;
        acc_next      = acc_reg;
        w_next        = w_reg;
        total_next    = total_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_acc_next    = m_acc_reg;
        m_weight_next = m_weight_reg;
        req           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    a_next    = IDX_W'(s_node_a);
                    b_next    = IDX_W'(s_node_b);
                    w_next    = s_edge_weight;
                    cur_next  = IDX_W'(s_node_a);
                    side_next = 1'b0;
                    acc_next  = 1'b0;
                    state_next = in_range ? ST_FIND_RD : ST_DONE;
                end
            end
            ST_FIND_RD: begin
                req.rd_en   = 1'b1;
                req.rd_addr = cur_reg;
                state_next  = ST_FIND_CHK;
            end
            ST_FIND_CHK: begin
                if (rd_data == cur_reg) begin
                    root_next  = cur_reg;
                    cur_next   = side_reg ? b_reg : a_reg;
                    state_next = ST_COMP_RD;
                end else begin
                    cur_next   = rd_data;
                    state_next = ST_FIND_RD;
                end
            end
            ST_COMP_RD: begin
                if (cur_reg == root_reg) begin
                    if (!side_reg) begin
                        root_a_next = root_reg;
                        cur_next    = b_reg;
                        side_next   = 1'b1;
                        state_next  = ST_FIND_RD;
                    end else begin
                        state_next = ST_LINK;
                    end
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = cur_reg;
                    state_next  = ST_COMP_WR;
                end
            end
            ST_COMP_WR: begin
                req.wr_en   = 1'b1;
                req.wr_addr = cur_reg;
                req.wr_data = root_reg;
                cur_next    = rd_data;
                state_next  = ST_COMP_RD;
            end
            ST_LINK: begin
                if (root_a_reg != root_reg) begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = root_a_reg;
                    req.wr_data = root_reg;
                    acc_next    = 1'b1;
                    total_next  = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_acc_next    = acc_reg;
                    m_weight_next = total_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            total_reg    <= '0;
            m_valid_reg  <= 1'b0;
            m_acc_reg    <= 1'b0;
            m_weight_reg <= '0;
        end else begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            m_valid_reg  <= m_valid_next;
            m_acc_reg    <= m_acc_next;
            m_weight_reg <= m_weight_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        cur_reg    <= cur_next;
        root_reg   <= root_next;
        root_a_reg <= root_a_next;
        side_reg   <= side_next;
        acc_reg    <= acc_next;
        w_reg      <= w_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_accepted    = m_acc_reg;
    assign m_tree_weight = m_weight_reg;

endmodule

@@ src/kufes_parent_table.sv @@
// Parent pointer table of the disjoint-set forest, one read and one write port.
// After reset it sweeps every entry to point at itself. Depends on kufes_pkg.
module kufes_parent_table
    import kufes_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mem_req_t req,
    output idx_t     rd_data,
    output logic     busy
);

    idx_t mem [NODES];
    idx_t rd_data_reg;
    idx_t clr_reg;
    idx_t clr_next;
    logic busy_reg;
    logic busy_next;

    always_comb begin
        clr_next  = clr_reg;
        busy_next = busy_reg;
        if (busy_reg) begin
            clr_next = clr_reg + 1'b1;
            if (clr_reg == IDX_W'(NODES - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end else begin
            clr_reg  <= clr_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[clr_reg] <= clr_reg;
        end else if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

@@ src/kufes_checker.sv @@
// Port-level checker for the Kruskal edge selection core, bound to the top level.
// Depends on kufes_pkg and kruskal_union_find_edge_select_core_assert.svh.
`include "kruskal_union_find_edge_select_core_assert.svh"

module kufes_checker
    import kufes_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [NODE_W-1:0]   s_node_a,
    input logic [NODE_W-1:0]   s_node_b,
    input logic [WEIGHT_W-1:0] s_edge_weight,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_accepted,
    input logic [TOTAL_W-1:0]  m_tree_weight
);

    logic s_fire;

    assign s_fire = s_valid && s_ready;

    `KUFES_ASSERT(a_input_holds, s_valid && !s_ready |=> s_valid && $stable(s_node_a) && $stable(s_node_b) && $stable(s_edge_weight), "Input item changed while waiting.")
    `KUFES_ASSERT(a_result_holds, m_valid && !m_ready |=> m_valid && $stable(m_accepted) && $stable(m_tree_weight), "Result changed while stalled.")
    `KUFES_ASSERT(a_busy_after_item, s_fire |=> !s_ready, "Core ready right after taking an item.")
    `KUFES_ASSERT_CLK(a_total_monotonic, aclk, aresetn, $past(aresetn) && (m_tree_weight != $past(m_tree_weight)) |-> (m_tree_weight > $past(m_tree_weight)), "Tree weight decreased.")

endmodule

bind kruskal_union_find_edge_select_core kufes_checker u_kufes_checker (.*);

@@ dv/testbench.sv @@
// Self-checking testbench for kruskal_union_find_edge_select_core: edges go in over valid/ready,
// and each select result is compared with a union-find predictor kept inside the bench.
// Depends on kufes_pkg and the core RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kufes_pkg::*;

    localparam int TARGET_ITEMS   = 1250;
    localparam int QUIET_LIMIT    = 40000;
    localparam int HOLD_AT        = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 64;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef struct {
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [WEIGHT_W-1:0] weight;
        bit                  drain;
    } edge_item_t;

    typedef struct {
        logic               accepted;
        logic [TOTAL_W-1:0] tree_weight;
    } mst_result_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [NODE_W-1:0]   s_node_a      = '0;
    logic [NODE_W-1:0]   s_node_b      = '0;
    logic [WEIGHT_W-1:0] s_edge_weight = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic                m_accepted;
    logic [TOTAL_W-1:0]  m_tree_weight;

    edge_item_t  edge_q[$];
    mst_result_t result_q[$];

    logic [NODE_W-1:0]  parent_of[NODES];
    logic [TOTAL_W-1:0] mst_total;

    int edges_in    = 0;
    int sent_count  = 0;
    int total_items = 1;
    int errors      = 0;
    int quiet       = 0;
    int hold_left   = 0;
    bit hold_done   = 0;

    kruskal_union_find_edge_select_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_node_a      (s_node_a),
        .s_node_b      (s_node_b),
        .s_edge_weight (s_edge_weight),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_accepted    (m_accepted),
        .m_tree_weight (m_tree_weight)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [NODE_W-1:0] root_of(logic [NODE_W-1:0] start);
        logic [NODE_W-1:0] r;
        logic [NODE_W-1:0] x;
        logic [NODE_W-1:0] nxt;
        int steps;
        r = start;
        steps = 0;
        while (parent_of[r] != r && steps < NODES) begin
            r = parent_of[r];
            steps++;
        end
        x = start;
        steps = 0;
        while (x != r && steps < NODES) begin
            nxt = parent_of[x];
            parent_of[x] = r;
            x = nxt;
            steps++;
        end
        return r;
    endfunction

    function automatic mst_result_t select_edge(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                                                logic [WEIGHT_W-1:0] w);
        mst_result_t res;
        logic [NODE_W-1:0] ra;
        logic [NODE_W-1:0] rb;
        res.accepted = 1'b0;
        if (int'(a) < NODES && int'(b) < NODES) begin
            ra = root_of(a);
            rb = root_of(b);
            if (ra != rb) begin
                parent_of[ra] = rb;
                res.accepted = 1'b1;
                if (TOTAL_W'(w) > TOTAL_MAX - mst_total) begin
                    mst_total = TOTAL_MAX;
                end else begin
                    mst_total = mst_total + TOTAL_W'(w);
                end
            end
        end
        res.tree_weight = mst_total;
        return res;
    endfunction

    // Idle percentage for the sender (side 0) or the receiver (side 1) in the current stage.
    function automatic int idle_pct(int side);
        int stage;
        stage = (edges_in * 3) / total_items;
        if (stage == 0) begin
            return (side == 0) ? 38 : 70;
        end else if (stage == 1) begin
            return (side == 0) ? 70 : 38;
        end
        return 0;
    endfunction

    task automatic add_edge(int a, int b, logic [WEIGHT_W-1:0] w, bit drain = 0);
        edge_item_t it;
        it.node_a = NODE_W'(a);
        it.node_b = NODE_W'(b);
        it.weight = w;
        it.drain  = drain;
        edge_q.push_back(it);
    endtask

    always @(negedge aclk) begin : driver
        edge_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && edges_in < sent_count) begin
            // Item still on offer; hold it.
        end else if (edge_q.size() == 0) begin
            s_valid <= 1'b0;
        end else if (edge_q[0].drain && result_q.size() != 0) begin
            s_valid <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct(0)) begin
            s_valid <= 1'b0;
        end else begin
            nxt = edge_q.pop_front();
            s_valid       <= 1'b1;
            s_node_a      <= nxt.node_a;
            s_node_b      <= nxt.node_b;
            s_edge_weight <= nxt.weight;
            sent_count++;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (!hold_done && edges_in >= HOLD_AT) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= idle_pct(1));
        end
    end

    always @(posedge aclk) begin : monitor
        mst_result_t exp_r;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                result_q.push_back(select_edge(s_node_a, s_node_b, s_edge_weight));
                edges_in++;
            end
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result accepted=%0b tree_weight=%0h",
                             $time, m_accepted, m_tree_weight);
                    errors++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (m_accepted !== exp_r.accepted) begin
                        $display("%0t: accepted mismatch, expected %0b actual %0b",
                                 $time, exp_r.accepted, m_accepted);
                        errors++;
                    end
                    if (m_tree_weight !== exp_r.tree_weight) begin
                        $display("%0t: tree_weight mismatch, expected %0h actual %0h",
                                 $time, exp_r.tree_weight, m_tree_weight);
                        errors++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= QUIET_LIMIT) begin
                    $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        logic [WEIGHT_W-1:0] w_run;
        int ptr;
        int pick;
        int len;
        int cnt;
        int a;
        int b;
        int base;

        for (int i = 0; i < NODES; i++) begin
            parent_of[i] = NODE_W'(i);
        end
        mst_total = '0;

        w_run = 32'd16;
        add_edge(0, 1023, 32'h0000_0000);
        add_edge(1023, 0, 32'hFFFF_FFFF);
        add_edge(5, 5, 32'h0000_0001);
        add_edge(1, 2, w_run);
        add_edge(2, 3, w_run + 1);
        add_edge(3, 4, w_run + 2);
        add_edge(4, 6, w_run + 3);
        add_edge(1, 7, w_run + 4);
        add_edge(1, 6, w_run + 5);
        add_edge(3, 1, w_run + 6);
        add_edge(512, 511, 32'h7FFF_FFFF);
        add_edge(682, 341, 32'hAAAA_AAAA);
        add_edge(341, 682, 32'h5555_5555);
        add_edge(511, 682, 32'h8000_0000);
        add_edge(1022, 0, 32'hFFFF_FFFF);
        add_edge(1023, 1022, 32'hFFFF_FFFF);
        add_edge(7, 7, 32'h0000_0000);
        add_edge(6, 512, 32'h0000_0100);

        ptr = 16;
        while (edge_q.size() < TARGET_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (edge_q.size() == 18 || (edge_q.size() >= 600 && edge_q.size() < 604)) begin
                add_edge(ptr, ptr + 1, w_run, 1);
                ptr = ptr + 2;
            end else if (pick < 25 && ptr + 42 < NODES) begin
                len = $urandom_range(3, 40);
                for (int i = 0; i < len; i++) begin
                    w_run = w_run + $urandom_range(0, 4096);
                    add_edge(ptr + i, ptr + i + 1, w_run);
                end
                w_run = w_run + $urandom_range(0, 4096);
                add_edge(ptr, $urandom_range(0, NODES - 1), w_run);
                add_edge(ptr + len, ptr, w_run);
                ptr = ptr + len + 1;
            end else if (pick < 75) begin
                base = (ptr > NODES - 16) ? NODES - 16 : ptr;
                cnt = $urandom_range(4, 12);
                for (int i = 0; i < cnt; i++) begin
                    w_run = w_run + $urandom_range(0, 4096);
                    add_edge(base + $urandom_range(0, 15), base + $urandom_range(0, 15), w_run);
                end
                ptr = (ptr + 8 > NODES - 16) ? NODES - 16 : ptr + 8;
            end else begin
                a = $urandom_range(0, NODES - 1);
                b = ($urandom_range(0, 3) == 0) ? a : $urandom_range(0, NODES - 1);
                add_edge(a, b, $urandom);
            end
        end
        total_items = edge_q.size();

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (edge_q.size() != 0 || edges_in != sent_count || result_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (result_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, result_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
